>>> src/lenorm_pkg.sv
package lenorm_pkg;

	localparam int CNT_W = 6;

	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_DEL = 8'd127;

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_CR   = 2'd1;
	localparam logic [1:0] PEND_LF   = 2'd2;

	localparam logic [2:0] MODE_CR   = 3'd0;
	localparam logic [2:0] MODE_LF   = 3'd1;
	localparam logic [2:0] MODE_CRLF = 3'd2;
	localparam logic [2:0] MODE_LFCR = 3'd3;
	localparam logic [2:0] MODE_KEEP = 3'd4;

	localparam logic [1:0] REG_ERASE_BS  = 2'd0;
	localparam logic [1:0] REG_ERASE_DEL = 2'd1;
	localparam logic [1:0] REG_EOL_MODE  = 2'd2;

	typedef struct packed {
		logic [1:0] tlen;
		logic [7:0] b0;
		logic [7:0] b1;
	} term_t;

	typedef struct packed {
		logic [CNT_W-1:0] len;
		logic [1:0]       tlen;
		logic [7:0]       t0;
		logic [7:0]       t1;
		logic             trunc;
		logic             last;
		logic             done;
	} job_t;

	function automatic term_t term_sel(input logic [2:0] mode, input logic [1:0] olen,
		input logic [7:0] o0, input logic [7:0] o1);
		term_t t;
		t.tlen = olen;
		t.b0   = o0;
		t.b1   = o1;
		unique case (mode)
			MODE_CR: begin
				t.tlen = 2'd1;
				t.b0   = CH_CR;
			end
			MODE_LF: begin
				t.tlen = 2'd1;
				t.b0   = CH_LF;
			end
			MODE_CRLF: begin
				t.tlen = 2'd2;
				t.b0   = CH_CR;
				t.b1   = CH_LF;
			end
			MODE_LFCR: begin
				t.tlen = 2'd2;
				t.b0   = CH_LF;
				t.b1   = CH_CR;
			end
			default: begin
				t.tlen = olen;
			end
		endcase
		return t;
	endfunction

endpackage

>>> src/lenorm_mem.sv
module lenorm_mem #(
	parameter int LINE_MAX = 32
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(LINE_MAX)-1:0] waddr,
	input  logic [7:0]                  wdata,
	input  logic                        re,
	input  logic [$clog2(LINE_MAX)-1:0] raddr,
	output logic [7:0]                  rdata
);

	logic [7:0] mem [LINE_MAX];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/lenorm_emit.sv
module lenorm_emit #(
	parameter int LINE_MAX = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  lenorm_pkg::job_t            job,
	output logic                        busy,
	output logic                        rd_en,
	output logic [$clog2(LINE_MAX)-1:0] rd_addr,
	input  logic [7:0]                  rd_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  out_byte,
	output logic                        last_of_run,
	output logic                        stream_done,
	output logic                        line_truncated
);

	localparam int AW = $clog2(LINE_MAX);

	logic                         busy_q;
	lenorm_pkg::job_t             job_q;
	logic [lenorm_pkg::CNT_W-1:0] pos_q;
	logic                         v_s1;
	logic                         mem_s1;
	logic [7:0]                   byte_s1;
	logic                         trunc_s1;
	logic                         last_s1;
	logic                         done_s1;
	logic                         out_v_q;
	logic [7:0]                   out_byte_q;
	logic                         out_last_q;
	logic                         out_done_q;
	logic                         out_trunc_q;
	logic                         load_out;
	logic                         issue;
	logic                         tok_mem;
	logic                         tok_last;
	logic [7:0]                   tok_byte;
	logic [lenorm_pkg::CNT_W-1:0] tok_end;

	assign load_out = v_s1 && (!out_v_q || !out_stall);
	assign issue    = busy_q && (!v_s1 || load_out);
	assign tok_mem  = pos_q < job_q.len;
	assign tok_end  = job_q.len + lenorm_pkg::CNT_W'(job_q.tlen) - lenorm_pkg::CNT_W'(1);
	assign tok_last = pos_q == tok_end;
	assign tok_byte = (pos_q == job_q.len) ? job_q.t0 : job_q.t1;

	assign busy    = busy_q;
	assign rd_en   = issue && tok_mem;
	assign rd_addr = pos_q[AW-1:0];

	assign out_valid      = out_v_q;
	assign out_byte       = out_byte_q;
	assign last_of_run    = out_last_q;
	assign stream_done    = out_done_q;
	assign line_truncated = out_trunc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (issue && tok_last) begin
				busy_q <= 1'b0;
			end
			if (issue) begin
				v_s1 <= 1'b1;
			end else if (load_out) begin
				v_s1 <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			job_q <= job;
			pos_q <= '0;
		end else if (issue) begin
			pos_q <= pos_q + lenorm_pkg::CNT_W'(1);
		end
		if (issue) begin
			mem_s1   <= tok_mem;
			byte_s1  <= tok_byte;
			trunc_s1 <= job_q.trunc;
			last_s1  <= tok_last && job_q.last;
			done_s1  <= tok_last && job_q.done;
		end
		if (load_out) begin
			out_byte_q  <= mem_s1 ? rd_data : byte_s1;
			out_last_q  <= last_s1;
			out_done_q  <= done_s1;
			out_trunc_q <= trunc_s1;
		end
	end

endmodule

>>> src/line_ending_normalizer_top.sv
// Line ending normalizer: buffers the characters of each text line in a line memory of LINE_MAX
// bytes with one write port and one read port, applies backspace/delete erasing, and replays the
// line followed by the terminator that eol_mode selects. Once an item that ends a line is taken,
// the line and its terminator leave the output at one byte per cycle while out_stall is low. The
// next input item waits until the replay has read the whole line and issued its terminator, and
// also until the new line's first character is written when the item that closed the line also
// starts the next one. Characters beyond LINE_MAX in one line are dropped and that line's output
// bytes carry line_truncated. The user must write configuration only while the block is idle;
// the block itself does not enforce this.
module line_ending_normalizer_top #(
	parameter int LINE_MAX = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [2:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_file,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       stream_done,
	output logic       line_truncated
);

	localparam int AW = $clog2(LINE_MAX);
	localparam int CW = lenorm_pkg::CNT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WR   = 2'd1;
	localparam logic [1:0] ST_J2   = 2'd2;

	logic             erase_bs_q;
	logic             erase_del_q;
	logic [2:0]       eol_mode_q;
	logic [CW-1:0]    cnt_q;
	logic [1:0]       pend_q;
	logic             ovf_q;
	logic [1:0]       state_q;
	logic [7:0]       wbyte_q;
	logic [AW-1:0]    waddr_q;
	logic             e2ne_q;
	lenorm_pkg::job_t job2_q;

	logic             accept;
	logic             is_cr;
	logic             is_lf;
	logic             erase;
	logic             e1;
	logic             paired;
	logic             proc;
	logic             plain;
	logic [CW-1:0]    cnt_a;
	logic             ovf_a;
	logic             room;
	logic             store;
	logic [CW-1:0]    cnt_b;
	logic             ovf_b;
	logic [1:0]       pend_b;
	logic             e2;
	logic             e2ne;
	lenorm_pkg::term_t term1;
	lenorm_pkg::term_t term2;
	lenorm_pkg::job_t  job1;
	lenorm_pkg::job_t  job2;

	logic             gen_busy;
	logic             gen_start;
	lenorm_pkg::job_t gen_job;
	logic             gen_rd_en;
	logic [AW-1:0]    gen_rd_addr;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [7:0]       mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [7:0]       mem_rdata;

	assign in_stall = (state_q != ST_IDLE) || gen_busy;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		is_cr  = in_byte == lenorm_pkg::CH_CR;
		is_lf  = in_byte == lenorm_pkg::CH_LF;
		erase  = (erase_bs_q && in_byte == lenorm_pkg::CH_BS) ||
			(erase_del_q && in_byte == lenorm_pkg::CH_DEL);
		e1     = pend_q != lenorm_pkg::PEND_NONE;
		paired = (pend_q == lenorm_pkg::PEND_CR && is_lf) ||
			(pend_q == lenorm_pkg::PEND_LF && is_cr);
		proc   = !paired;
		plain  = proc && !is_cr && !is_lf && !erase;
		cnt_a  = e1 ? '0 : cnt_q;
		ovf_a  = e1 ? 1'b0 : ovf_q;
		room   = cnt_a < CW'(LINE_MAX);
		store  = plain && room;
		ovf_b  = ovf_a || (plain && !room);
		if (store) begin
			cnt_b = cnt_a + CW'(1);
		end else if (proc && erase && cnt_a != '0) begin
			cnt_b = cnt_a - CW'(1);
		end else begin
			cnt_b = cnt_a;
		end
		if (proc && is_cr) begin
			pend_b = lenorm_pkg::PEND_CR;
		end else if (proc && is_lf) begin
			pend_b = lenorm_pkg::PEND_LF;
		end else begin
			pend_b = lenorm_pkg::PEND_NONE;
		end

		term1 = lenorm_pkg::term_sel(eol_mode_q, paired ? 2'd2 : 2'd1,
			(pend_q == lenorm_pkg::PEND_CR) ? lenorm_pkg::CH_CR : lenorm_pkg::CH_LF, in_byte);
		term2 = lenorm_pkg::term_sel(eol_mode_q,
			(pend_b != lenorm_pkg::PEND_NONE) ? 2'd1 : 2'd0,
			(pend_b == lenorm_pkg::PEND_CR) ? lenorm_pkg::CH_CR : lenorm_pkg::CH_LF,
			lenorm_pkg::CH_LF);
		e2   = end_of_file && (pend_b != lenorm_pkg::PEND_NONE || cnt_b != '0 || ovf_b);
		e2ne = e2 && (cnt_b != '0 || term2.tlen != 2'd0);

		job1.len   = cnt_q;
		job1.tlen  = term1.tlen;
		job1.t0    = term1.b0;
		job1.t1    = term1.b1;
		job1.trunc = ovf_q;
		job1.last  = !e2ne;
		job1.done  = end_of_file && !e2ne;

		job2.len   = cnt_b;
		job2.tlen  = term2.tlen;
		job2.t0    = term2.b0;
		job2.t1    = term2.b1;
		job2.trunc = ovf_b;
		job2.last  = 1'b1;
		job2.done  = end_of_file;
	end

	always_comb begin
		gen_start = 1'b0;
		gen_job   = job2_q;
		mem_we    = 1'b0;
		mem_waddr = waddr_q;
		mem_wdata = wbyte_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (e1) begin
						gen_start = 1'b1;
						gen_job   = job1;
					end else begin
						mem_we    = store;
						mem_waddr = cnt_a[AW-1:0];
						mem_wdata = in_byte;
						gen_start = e2ne;
						gen_job   = job2;
					end
				end
			end
			ST_WR: begin
				if (!gen_busy) begin
					mem_we    = 1'b1;
					gen_start = e2ne_q;
				end
			end
			ST_J2: begin
				gen_start = !gen_busy;
			end
			default: begin
				gen_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_bs_q  <= 1'b0;
			erase_del_q <= 1'b0;
			eol_mode_q  <= lenorm_pkg::MODE_KEEP;
			cnt_q       <= '0;
			pend_q      <= lenorm_pkg::PEND_NONE;
			ovf_q       <= 1'b0;
			state_q     <= ST_IDLE;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lenorm_pkg::REG_ERASE_BS:  erase_bs_q  <= cfg_data[0];
					lenorm_pkg::REG_ERASE_DEL: erase_del_q <= cfg_data[0];
					lenorm_pkg::REG_EOL_MODE:  eol_mode_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (end_of_file) begin
							cnt_q  <= '0;
							pend_q <= lenorm_pkg::PEND_NONE;
							ovf_q  <= 1'b0;
						end else begin
							cnt_q  <= cnt_b;
							pend_q <= pend_b;
							ovf_q  <= ovf_b;
						end
						if (e1 && store) begin
							state_q <= ST_WR;
						end else if (e1 && e2ne) begin
							state_q <= ST_J2;
						end
					end
				end
				ST_WR: begin
					if (!gen_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_J2: begin
					if (!gen_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wbyte_q <= in_byte;
			waddr_q <= cnt_a[AW-1:0];
			e2ne_q  <= e2ne;
			job2_q  <= job2;
		end
	end

	assign mem_re    = gen_rd_en;
	assign mem_raddr = gen_rd_addr;

	lenorm_mem #(
		.LINE_MAX(LINE_MAX)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	lenorm_emit #(
		.LINE_MAX(LINE_MAX)
	) u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (gen_start),
		.job            (gen_job),
		.busy           (gen_busy),
		.rd_en          (gen_rd_en),
		.rd_addr        (gen_rd_addr),
		.rd_data        (mem_rdata),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.last_of_run    (last_of_run),
		.stream_done    (stream_done),
		.line_truncated (line_truncated)
	);

endmodule

>>> sim/tb_line_ending_normalizer_top.sv
module tb_line_ending_normalizer_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_MAX    = 32;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 50;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
		logic       trunc;
	} out_byte_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [2:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       end_of_file;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       stream_done;
	logic       line_truncated;

	out_byte_t  expected_bytes[$];
	out_byte_t  held_byte;
	logic       have_held;

	logic [7:0] line_buf [LINE_MAX];
	int         char_cnt;
	logic [1:0] pend_term;
	logic       overflow_flag;
	logic       erase_bs_r;
	logic       erase_del_r;
	logic [2:0] eol_mode_r;

	int         items_sent;
	int         mismatches;
	int         quiet_cycles;
	logic       idle_en;
	logic       stall_en;

	line_ending_normalizer_top #(
		.LINE_MAX(LINE_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.end_of_file(end_of_file),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last_of_run(last_of_run),
		.stream_done(stream_done),
		.line_truncated(line_truncated)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void queue_byte(input logic [7:0] b);
		if (have_held)
			expected_bytes.push_back(held_byte);
		held_byte.data  = b;
		held_byte.last  = 1'b0;
		held_byte.done  = 1'b0;
		held_byte.trunc = overflow_flag;
		have_held = 1'b1;
	endfunction

	function automatic void replay_line(input logic [7:0] t0, input logic [7:0] t1,
		input int tlen);
		for (int i = 0; i < char_cnt; i++)
			queue_byte(line_buf[i]);
		case (eol_mode_r)
			lenorm_pkg::MODE_CR: queue_byte(lenorm_pkg::CH_CR);
			lenorm_pkg::MODE_LF: queue_byte(lenorm_pkg::CH_LF);
			lenorm_pkg::MODE_CRLF: begin
				queue_byte(lenorm_pkg::CH_CR);
				queue_byte(lenorm_pkg::CH_LF);
			end
			lenorm_pkg::MODE_LFCR: begin
				queue_byte(lenorm_pkg::CH_LF);
				queue_byte(lenorm_pkg::CH_CR);
			end
			default: begin
				if (tlen > 0)
					queue_byte(t0);
				if (tlen > 1)
					queue_byte(t1);
			end
		endcase
		char_cnt = 0;
		overflow_flag = 1'b0;
	endfunction

	function automatic void normalize_byte(input logic [7:0] b, input logic eof);
		logic       paired;
		logic [7:0] pb;
		paired = 1'b0;
		have_held = 1'b0;
		if (pend_term != lenorm_pkg::PEND_NONE) begin
			pb = (pend_term == lenorm_pkg::PEND_CR) ? lenorm_pkg::CH_CR : lenorm_pkg::CH_LF;
			if ((pend_term == lenorm_pkg::PEND_CR && b == lenorm_pkg::CH_LF) ||
				(pend_term == lenorm_pkg::PEND_LF && b == lenorm_pkg::CH_CR)) begin
				replay_line(pb, b, 2);
				paired = 1'b1;
			end else begin
				replay_line(pb, 8'h00, 1);
			end
			pend_term = lenorm_pkg::PEND_NONE;
		end
		if (!paired) begin
			if (b == lenorm_pkg::CH_CR) begin
				pend_term = lenorm_pkg::PEND_CR;
			end else if (b == lenorm_pkg::CH_LF) begin
				pend_term = lenorm_pkg::PEND_LF;
			end else if ((erase_bs_r && b == lenorm_pkg::CH_BS) ||
				(erase_del_r && b == lenorm_pkg::CH_DEL)) begin
				if (char_cnt > 0)
					char_cnt--;
			end else if (char_cnt < LINE_MAX) begin
				line_buf[char_cnt] = b;
				char_cnt++;
			end else begin
				overflow_flag = 1'b1;
			end
		end
		if (eof) begin
			if (pend_term != lenorm_pkg::PEND_NONE)
				replay_line((pend_term == lenorm_pkg::PEND_CR) ? lenorm_pkg::CH_CR :
					lenorm_pkg::CH_LF, 8'h00, 1);
			else if (char_cnt > 0 || overflow_flag)
				replay_line(8'h00, 8'h00, 0);
			char_cnt = 0;
			pend_term = lenorm_pkg::PEND_NONE;
			overflow_flag = 1'b0;
		end
		if (have_held) begin
			held_byte.last = 1'b1;
			held_byte.done = eof;
			expected_bytes.push_back(held_byte);
			have_held = 1'b0;
		end
	endfunction

	task automatic send_item(input logic [7:0] b, input logic eof);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		in_byte     <= b;
		end_of_file <= eof;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		normalize_byte(b, eof);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [2:0] value);
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			lenorm_pkg::REG_ERASE_BS:  erase_bs_r = value[0];
			lenorm_pkg::REG_ERASE_DEL: erase_del_r = value[0];
			lenorm_pkg::REG_EOL_MODE:  eol_mode_r = value;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic bs, input logic del, input logic [2:0] mode);
		write_reg(lenorm_pkg::REG_ERASE_BS, {2'b00, bs});
		write_reg(lenorm_pkg::REG_ERASE_DEL, {2'b00, del});
		write_reg(lenorm_pkg::REG_EOL_MODE, mode);
	endtask

	// Reset configuration: keep mode, erasing off.
	task automatic test_terminators_keep();
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(lenorm_pkg::CH_BS, 1'b0);
		send_item(lenorm_pkg::CH_DEL, 1'b0);
		send_item(lenorm_pkg::CH_CR, 1'b0);
		send_item(lenorm_pkg::CH_LF, 1'b0);
		send_text("c");
		send_item(lenorm_pkg::CH_LF, 1'b0);
		send_item(lenorm_pkg::CH_CR, 1'b0);
		send_text("d");
		send_item(lenorm_pkg::CH_CR, 1'b0);
		send_text("e");
		send_item(lenorm_pkg::CH_LF, 1'b0);
		send_item(lenorm_pkg::CH_LF, 1'b0);
		send_item(lenorm_pkg::CH_CR, 1'b0);
		send_item(lenorm_pkg::CH_CR, 1'b1);
		send_text("xy");
		send_item(8'h7E, 1'b1);
		send_text("q");
		send_item(lenorm_pkg::CH_CR, 1'b0);
		send_item(lenorm_pkg::CH_LF, 1'b1);
	endtask

	task automatic test_erase_and_flush();
		set_config(1'b1, 1'b1, lenorm_pkg::MODE_CRLF);
		send_item(lenorm_pkg::CH_BS, 1'b0);
		send_text("ab");
		send_item(lenorm_pkg::CH_BS, 1'b0);
		send_text("c");
		send_item(lenorm_pkg::CH_DEL, 1'b0);
		send_item(lenorm_pkg::CH_DEL, 1'b0);
		send_item(lenorm_pkg::CH_DEL, 1'b0);
		send_text("d");
		send_item(lenorm_pkg::CH_CR, 1'b0);
		send_item(lenorm_pkg::CH_BS, 1'b1);
		write_reg(lenorm_pkg::REG_EOL_MODE, lenorm_pkg::MODE_CR);
		send_text("e");
		send_item(lenorm_pkg::CH_LF, 1'b0);
		send_item(8'h80, 1'b1);
	endtask

	task automatic test_line_overflow();
		set_config(1'b1, 1'b0, lenorm_pkg::MODE_LF);
		for (int i = 0; i < LINE_MAX + 2; i++)
			send_item(8'h41 + 8'(i % 26), 1'b0);
		send_item(lenorm_pkg::CH_BS, 1'b0);
		send_text("Z");
		send_item(lenorm_pkg::CH_LF, 1'b0);
		send_text("ok");
		send_item(lenorm_pkg::CH_LF, 1'b1);
	endtask

	task automatic send_random_line(input int n_chars);
		logic [7:0] b;
		int         pick;
		for (int i = 0; i < n_chars; i++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				b = lenorm_pkg::CH_BS;
			else if (pick == 1)
				b = lenorm_pkg::CH_DEL;
			else if (pick == 2)
				b = 8'($urandom_range(0, 255));
			else
				b = 8'($urandom_range(32, 126));
			send_item(b, $urandom_range(0, 79) == 0);
		end
		case ($urandom_range(0, 6))
			0, 1: begin
				send_item(lenorm_pkg::CH_CR, 1'b0);
				send_item(lenorm_pkg::CH_LF, 1'b0);
			end
			2: begin
				send_item(lenorm_pkg::CH_LF, 1'b0);
				send_item(lenorm_pkg::CH_CR, 1'b0);
			end
			3: send_item(lenorm_pkg::CH_CR, 1'b0);
			4: send_item(lenorm_pkg::CH_LF, 1'b0);
			5: begin
				send_item(lenorm_pkg::CH_CR, 1'b0);
				send_item(lenorm_pkg::CH_CR, 1'b0);
			end
			default: ;
		endcase
	endtask

	task automatic test_random_phase(input logic bs, input logic del, input logic [2:0] mode,
		input int n_items);
		int stop_at;
		set_config(bs, del, mode);
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0)
				send_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
			else if ($urandom_range(0, 7) == 0)
				send_random_line($urandom_range(28, 45));
			else
				send_random_line($urandom_range(0, 10));
		end
		send_item(8'($urandom_range(32, 126)), 1'b1);
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= lenorm_pkg::REG_ERASE_BS;
		cfg_data    <= 3'd0;
		in_valid    <= 1'b0;
		in_byte     <= 8'h00;
		end_of_file <= 1'b0;
		char_cnt      = 0;
		pend_term     = lenorm_pkg::PEND_NONE;
		overflow_flag = 1'b0;
		erase_bs_r    = 1'b0;
		erase_del_r   = 1'b0;
		eol_mode_r    = lenorm_pkg::MODE_KEEP;
		have_held     = 1'b0;
		items_sent    = 0;
		mismatches    = 0;
		idle_en       = 1'b1;
		stall_en      = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_terminators_keep();
		test_erase_and_flush();
		test_line_overflow();
		test_random_phase(1'b0, 1'b0, lenorm_pkg::MODE_CR, 30);
		test_random_phase(1'b1, 1'b1, lenorm_pkg::MODE_LF, 30);
		test_random_phase(1'b1, 1'b0, lenorm_pkg::MODE_CRLF, 30);
		test_random_phase(1'b0, 1'b1, lenorm_pkg::MODE_LFCR, 30);
		test_random_phase(1'b1, 1'b1, lenorm_pkg::MODE_KEEP, 30);
		test_random_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			3'($urandom_range(5, 7)), 25);
		idle_en  = 1'b0;
		stall_en = 1'b0;
		test_random_phase(1'b1, 1'b1, lenorm_pkg::MODE_CRLF, 30);
		in_valid <= 1'b0;

		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && expected_bytes.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_en && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_output
		out_byte_t want;
		out_byte_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.data  = out_byte;
			got.last  = last_of_run;
			got.done  = stream_done;
			got.trunc = line_truncated;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output: byte %02h last %0b done %0b trunc %0b",
						got.data, got.last, got.done, got.trunc);
			end else begin
				want = expected_bytes.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
							want.data, want.last, want.done, want.trunc,
							got.data, got.last, got.done, got.trunc);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
